// ===== rtl/dpw_pkg.sv =====
// Package for the depth pixel to world point block.
// Holds the field widths, register indexes and shared types; no dependencies.
package dpw_pkg;

  localparam int DEPTH_BITS = 16;
  localparam int COORD_BITS = 12;

  localparam int DEPTH_W = 16;
  localparam int COORD_W = 12;
  localparam int WORLD_W = 32;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [DEPTH_W-1:0] DEPTH_MASK = DEPTH_W'((64'd1 << DEPTH_BITS) - 64'd1);
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRINCIPAL_POINT = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_X = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Y = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW_Z = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 8'd7;

  localparam logic [23:0] RST_DEPTH_SCALE = 24'd16777;
  localparam logic [23:0] RST_INV_FOCAL = 24'd27962;
  localparam logic [31:0] RST_PRINCIPAL_POINT = 32'd251663360;
  localparam logic [47:0] RST_ROT_ROW_X = 48'd16384;
  localparam logic [47:0] RST_ROT_ROW_Y = 48'd1073741824;
  localparam logic [47:0] RST_ROT_ROW_Z = 48'd70368744177664;
  localparam logic [47:0] RST_TRANSLATION = 48'd0;

  // Load enables for the three register stages of one world axis.
  typedef struct packed {
    logic en_prod;
    logic en_acc;
    logic en_out;
  } axis_ctl_t;

endpackage

// ===== rtl/dpw_ifs.sv =====
// Channel interfaces for the depth pixel to world point block.
// Depends on dpw_pkg for the field widths.
interface dpw_pixel_if;
  logic valid;
  logic ready;
  logic [dpw_pkg::DEPTH_W-1:0] depth;
  logic [dpw_pkg::COORD_W-1:0] col;
  logic [dpw_pkg::COORD_W-1:0] row;
  modport source (output valid, output depth, output col, output row, input ready);
  modport sink (input valid, input depth, input col, input row, output ready);
endinterface

interface dpw_point_if;
  logic valid;
  logic ready;
  logic signed [dpw_pkg::WORLD_W-1:0] world_x;
  logic signed [dpw_pkg::WORLD_W-1:0] world_y;
  logic signed [dpw_pkg::WORLD_W-1:0] world_z;
  modport source (output valid, output world_x, output world_y, output world_z, input ready);
  modport sink (input valid, input world_x, input world_y, input world_z, output ready);
endinterface

interface dpw_cfg_if;
  logic valid;
  logic ready;
  logic [dpw_pkg::CFG_IDX_W-1:0] index;
  logic [dpw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/dpw_axis.sv =====
// One world axis: three rotation products, their sum with the translation,
// then rounding and saturation to Q16.16. Depends on dpw_pkg.
module dpw_axis (
  input  logic                clk,
  input  dpw_pkg::axis_ctl_t  ctl,
  input  logic [47:0]         coef_row,
  input  logic [15:0]         trans,
  input  logic signed [31:0]  cam_x,
  input  logic signed [31:0]  cam_y,
  input  logic signed [31:0]  cam_z,
  output logic signed [31:0]  world
);
  import dpw_pkg::*;

  logic signed [47:0] prod_x;
  logic signed [47:0] prod_y;
  logic signed [47:0] prod_z;
  logic signed [50:0] acc;
  logic signed [50:0] acc_rnd;
  logic signed [36:0] acc_sh;
  logic signed [31:0] world_next;

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      prod_x <= 48'($signed(coef_row[15:0])) * 48'(cam_x);
      prod_y <= 48'($signed(coef_row[31:16])) * 48'(cam_y);
      prod_z <= 48'($signed(coef_row[47:32])) * 48'(cam_z);
    end
    if (ctl.en_acc) begin
      acc <= 51'(prod_x) + 51'(prod_y) + 51'(prod_z) + (51'($signed(trans)) <<< 22);
    end
    if (ctl.en_out) begin
      world <= world_next;
    end
  end

  always_comb begin
    acc_rnd = acc + 51'sd8192;
    acc_sh = 37'(acc_rnd >>> 14);
    if (acc_sh > 37'sd2147483647) begin
      world_next = 32'sh7FFFFFFF;
    end else if (acc_sh < -37'sd2147483648) begin
      world_next = 32'sh80000000;
    end else begin
      world_next = 32'(acc_sh);
    end
  end

endmodule

// ===== rtl/depth_pixel_to_world_point.sv =====
// Depth pixel to world point: scales a raw depth to z, back-projects the pixel through the
// inverse pinhole intrinsics and applies the rigid rotation and translation, all in fixed point
// with round-half-up and saturation. The pipeline has seven register stages and takes one pixel
// every clock while the output is not held back; back-pressure stalls only the stages that are
// full. The multipliers (depth scale, focal scaling, z product, rotation) each sit in a stage
// of their own. Configuration registers reset to the identity extrinsic and should be written
// only while no pixel is in flight. Depends on dpw_pkg, dpw_ifs and dpw_axis.
module depth_pixel_to_world_point (
  input logic clk,
  input logic rst,
  dpw_cfg_if.sink     cfg,
  dpw_pixel_if.sink   pixel,
  dpw_point_if.source point
);
  import dpw_pkg::*;

  logic [23:0] depth_scale;
  logic [23:0] inv_focal_x;
  logic [23:0] inv_focal_y;
  logic [31:0] principal_point;
  logic [47:0] rot_row_x;
  logic [47:0] rot_row_y;
  logic [47:0] rot_row_z;
  logic [47:0] translation;

  logic [6:0] v;
  logic [6:0] en;
  logic [2:0] in_flight;

  logic [DEPTH_W-1:0] d_m;
  logic [COORD_W-1:0] u_m;
  logic [COORD_W-1:0] v_m;

  logic [39:0]        zprod_a;
  logic signed [17:0] du_a;
  logic signed [17:0] dv_a;

  logic [39:0]        zprod_rnd;
  logic [30:0]        z_next;
  logic signed [42:0] px_full;
  logic signed [42:0] py_full;
  logic [30:0]        z_b;
  logic signed [41:0] px_b;
  logic signed [41:0] py_b;

  logic signed [41:0] px_rnd;
  logic signed [41:0] py_rnd;
  logic signed [29:0] nx;
  logic signed [29:0] ny;
  logic [30:0]        z_c;
  logic signed [61:0] xz_c;
  logic signed [61:0] yz_c;

  logic signed [61:0] xz_rnd;
  logic signed [61:0] yz_rnd;
  logic signed [45:0] xz_sh;
  logic signed [45:0] yz_sh;
  logic signed [31:0] xc_next;
  logic signed [31:0] yc_next;
  logic signed [31:0] xc_d;
  logic signed [31:0] yc_d;
  logic signed [31:0] zc_d;

  axis_ctl_t axis_ctl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_scale <= RST_DEPTH_SCALE;
      inv_focal_x <= RST_INV_FOCAL;
      inv_focal_y <= RST_INV_FOCAL;
      principal_point <= RST_PRINCIPAL_POINT;
      rot_row_x <= RST_ROT_ROW_X;
      rot_row_y <= RST_ROT_ROW_Y;
      rot_row_z <= RST_ROT_ROW_Z;
      translation <= RST_TRANSLATION;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DEPTH_SCALE:     depth_scale <= cfg.data[23:0];
        REG_INV_FOCAL_X:     inv_focal_x <= cfg.data[23:0];
        REG_INV_FOCAL_Y:     inv_focal_y <= cfg.data[23:0];
        REG_PRINCIPAL_POINT: principal_point <= cfg.data[31:0];
        REG_ROT_ROW_X:       rot_row_x <= cfg.data;
        REG_ROT_ROW_Y:       rot_row_y <= cfg.data;
        REG_ROT_ROW_Z:       rot_row_z <= cfg.data;
        REG_TRANSLATION:     translation <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[6] = !v[6] || point.ready;
    for (int i = 5; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pixel.ready = en[0];
  assign point.valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel.valid;
      end
      for (int i = 1; i < 7; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign d_m = pixel.depth & DEPTH_MASK;
  assign u_m = pixel.col & COORD_MASK;
  assign v_m = pixel.row & COORD_MASK;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      zprod_a <= 40'(d_m) * 40'(depth_scale);
      du_a <= $signed({2'b00, u_m, 4'b0000}) - $signed({2'b00, principal_point[15:0]});
      dv_a <= $signed({2'b00, v_m, 4'b0000}) - $signed({2'b00, principal_point[31:16]});
    end
  end

  always_comb begin
    zprod_rnd = zprod_a + 40'd128;
    z_next = zprod_rnd[39] ? 31'h7FFFFFFF : zprod_rnd[38:8];
    px_full = 43'(du_a) * 43'($signed({1'b0, inv_focal_x}));
    py_full = 43'(dv_a) * 43'($signed({1'b0, inv_focal_y}));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      z_b <= z_next;
      px_b <= px_full[41:0];
      py_b <= py_full[41:0];
    end
  end

  always_comb begin
    px_rnd = px_b + 42'sd2048;
    py_rnd = py_b + 42'sd2048;
    nx = 30'(px_rnd >>> 12);
    ny = 30'(py_rnd >>> 12);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      z_c <= z_b;
      xz_c <= 62'(nx) * 62'($signed({1'b0, z_b}));
      yz_c <= 62'(ny) * 62'($signed({1'b0, z_b}));
    end
  end

  always_comb begin
    xz_rnd = xz_c + 62'sd32768;
    yz_rnd = yz_c + 62'sd32768;
    xz_sh = 46'(xz_rnd >>> 16);
    yz_sh = 46'(yz_rnd >>> 16);
    if (xz_sh > 46'sd2147483647) begin
      xc_next = 32'sh7FFFFFFF;
    end else if (xz_sh < -46'sd2147483648) begin
      xc_next = 32'sh80000000;
    end else begin
      xc_next = 32'(xz_sh);
    end
    if (yz_sh > 46'sd2147483647) begin
      yc_next = 32'sh7FFFFFFF;
    end else if (yz_sh < -46'sd2147483648) begin
      yc_next = 32'sh80000000;
    end else begin
      yc_next = 32'(yz_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      xc_d <= xc_next;
      yc_d <= yc_next;
      zc_d <= $signed({1'b0, z_c});
    end
  end

  assign axis_ctl = '{en_prod: en[4], en_acc: en[5], en_out: en[6]};

  dpw_axis u_axis_x (
    .clk      (clk),
    .ctl      (axis_ctl),
    .coef_row (rot_row_x),
    .trans    (translation[15:0]),
    .cam_x    (xc_d),
    .cam_y    (yc_d),
    .cam_z    (zc_d),
    .world    (point.world_x)
  );

  dpw_axis u_axis_y (
    .clk      (clk),
    .ctl      (axis_ctl),
    .coef_row (rot_row_y),
    .trans    (translation[31:16]),
    .cam_x    (xc_d),
    .cam_y    (yc_d),
    .cam_z    (zc_d),
    .world    (point.world_y)
  );

  dpw_axis u_axis_z (
    .clk      (clk),
    .ctl      (axis_ctl),
    .coef_row (rot_row_z),
    .trans    (translation[47:32]),
    .cam_x    (xc_d),
    .cam_y    (yc_d),
    .cam_z    (zc_d),
    .world    (point.world_z)
  );

  // Count of words in flight, kept to check the stage valid bits against.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 3'(pixel.valid && pixel.ready) - 3'(point.valid && point.ready);
    end
  end

  a_reset_empties: assert property (@(posedge clk) rst |=> v == 7'd0)
    else $error("pipeline not empty after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> v == 7'h7F)
    else $error("input stalled while a stage is empty");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    $countones(v) == 32'(in_flight))
    else $error("words lost or repeated in the pipeline");

endmodule
